>>> hw/rtl/beacon_request_responder_defines.svh
// Assertion helpers for the beacon request responder.
`ifndef BEACON_REQUEST_RESPONDER_DEFINES_SVH
`define BEACON_REQUEST_RESPONDER_DEFINES_SVH

`ifndef SYNTHESIS
`define BRR_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define BRR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BRR_ASSERT_SAME(name, clk, rst, ante, cons, msg)
`define BRR_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif

`endif

>>> hw/rtl/bcn_pkg.sv
`timescale 1ns / 1ps
package bcn_pkg;

  localparam int CFG_W = 64;

  typedef enum logic [2:0] {
    CFG_PAN_ID         = 3'd0,
    CFG_SOURCE_ADDRESS = 3'd1,
    CFG_SHORT_MODE     = 3'd2,
    CFG_EXT_PAN_ID     = 3'd3
  } cfg_index_t;

  localparam logic [2:0]  KIND_COMMAND       = 3'h3;
  localparam logic [7:0]  CMD_BEACON_REQUEST = 8'h07;
  localparam logic [15:0] FCS_POLY           = 16'h8408;
  localparam logic [3:0]  POS_MAX            = 4'd15;
  localparam logic [3:0]  POS_CMD            = 4'd7;

  // beacon layout, long-address positions
  localparam logic [5:0] LI_FC_HI    = 6'd1;
  localparam logic [5:0] LI_SEQ      = 6'd2;
  localparam logic [5:0] LI_PAN_LO   = 6'd3;
  localparam logic [5:0] LI_PAN_HI   = 6'd4;
  localparam logic [5:0] LI_SRC      = 6'd5;
  localparam logic [5:0] LI_SHORT_GAP = 6'd7;
  localparam logic [5:0] LI_SF_LO    = 6'd13;
  localparam logic [5:0] LI_SF_HI    = 6'd14;
  localparam logic [5:0] LI_PEND_ADR = 6'd17;
  localparam logic [5:0] LI_PROTO    = 6'd18;
  localparam logic [5:0] LI_STACK    = 6'd19;
  localparam logic [5:0] LI_EXT      = 6'd20;
  localparam logic [5:0] LI_TAIL     = 6'd28;
  localparam logic [5:0] LI_UPDATE   = 6'd31;
  localparam logic [5:0] LI_FCS_LO   = 6'd32;
  localparam logic [5:0] LI_FCS_HI   = 6'd33;
  localparam logic [5:0] SHORT_SKIP  = 6'd6;

  typedef struct packed {
    logic [15:0] pan_id;
    logic [63:0] source_address;
    logic        short_mode;
    logic [63:0] extended_pan_id;
  } cfg_t;

  typedef struct packed {
    logic [3:0] pos;
  } rx_status_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] seq;
  } tx_status_t;

  function automatic logic [15:0] fcs_byte(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    logic        bit_in;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      bit_in = b[k] ^ c[0];
      c = c >> 1;
      if (bit_in) begin
        c = c ^ FCS_POLY;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] beacon_byte(logic [5:0] li, logic short_mode, cfg_t cfg,
                                             logic [7:0] seq, logic [15:0] crc);
    logic [7:0] r;
    logic [2:0] k_src;
    logic [2:0] k_ext;
    k_src = 3'(li - LI_SRC);
    k_ext = 3'(li - LI_EXT);
    r = 8'h00;
    if (li == LI_FC_HI) begin
      r = short_mode ? 8'h80 : 8'hC0;
    end else if (li == LI_SEQ) begin
      r = seq;
    end else if (li == LI_PAN_LO) begin
      r = cfg.pan_id[7:0];
    end else if (li == LI_PAN_HI) begin
      r = cfg.pan_id[15:8];
    end else if (li >= LI_SRC && li < LI_SF_LO) begin
      r = cfg.source_address[8*k_src +: 8];
    end else if (li == LI_SF_LO) begin
      r = 8'hFF;
    end else if (li == LI_SF_HI) begin
      r = 8'hCF;
    end else if (li == LI_PROTO) begin
      r = 8'h20;
    end else if (li == LI_STACK) begin
      r = 8'h84;
    end else if (li >= LI_EXT && li < LI_TAIL) begin
      r = cfg.extended_pan_id[8*k_ext +: 8];
    end else if (li >= LI_TAIL && li < LI_UPDATE) begin
      r = 8'hFF;
    end else if (li == LI_FCS_LO) begin
      r = crc[7:0];
    end else if (li == LI_FCS_HI) begin
      r = crc[15:8];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/bcn_rx_if.sv
`timescale 1ns / 1ps
interface bcn_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_last;
  modport source(output valid, rx_byte, rx_last, input ready);
  modport sink(input valid, rx_byte, rx_last, output ready);
endinterface

>>> hw/rtl/bcn_tx_if.sv
`timescale 1ns / 1ps
interface bcn_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_last;
  modport source(output valid, tx_byte, tx_last, input ready);
  modport sink(input valid, tx_byte, tx_last, output ready);
endinterface

>>> hw/rtl/bcn_queue.sv
`timescale 1ns / 1ps
module bcn_queue #(
  parameter int Depth = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic                       push_data,
  input  logic                       pop,
  output logic                       pop_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(Depth+1)-1:0] count
);

  localparam int CntW = $clog2(Depth + 1);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic            do_push;
  logic            do_pop;

  assign full     = (count == CntW'(Depth));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        mem[wr_ptr] <= push_data;
        wr_ptr      <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/bcn_rx.sv
`timescale 1ns / 1ps
module bcn_rx (
  input  logic                clk,
  input  logic                rst,
  bcn_rx_if.sink              rx,
  input  logic                q_full,
  output logic                push,
  output bcn_pkg::rx_status_t stat
);
  import bcn_pkg::*;

  logic [3:0] pos;
  logic [2:0] kind;
  logic [7:0] cmd;
  logic [2:0] kind_next;
  logic [7:0] cmd_next;
  logic       accept;

  assign rx.ready  = !q_full;
  assign accept    = rx.valid && rx.ready;
  assign kind_next = (pos == '0) ? rx.rx_byte[2:0] : kind;
  assign cmd_next  = (pos == POS_CMD) ? rx.rx_byte : cmd;
  assign push      = accept && rx.rx_last && (pos >= POS_CMD) &&
                     (kind_next == KIND_COMMAND) && (cmd_next == CMD_BEACON_REQUEST);
  assign stat.pos  = pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      kind <= '0;
      cmd  <= '0;
    end else if (accept) begin
      kind <= kind_next;
      cmd  <= cmd_next;
      if (rx.rx_last) begin
        pos <= '0;
      end else if (pos != POS_MAX) begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/bcn_tx.sv
`timescale 1ns / 1ps
module bcn_tx (
  input  logic                clk,
  input  logic                rst,
  input  bcn_pkg::cfg_t       cfg,
  input  logic                q_empty,
  input  logic                q_short,
  output logic                pop,
  bcn_tx_if.source            tx,
  output bcn_pkg::tx_status_t stat
);
  import bcn_pkg::*;

  logic        busy;
  logic [5:0]  idx;
  logic [15:0] crc;
  logic        short_mode;
  logic [7:0]  seq;
  logic [5:0]  li;
  logic [7:0]  byte_now;
  logic        last_now;
  logic        adv;

  assign li       = (short_mode && idx >= LI_SHORT_GAP) ? idx + SHORT_SKIP : idx;
  assign byte_now = beacon_byte(li, short_mode, cfg, seq, crc);
  assign last_now = (li == LI_FCS_HI);
  assign adv      = busy && (!tx.valid || tx.ready);
  assign pop      = !busy && !q_empty;
  assign stat     = '{busy: busy, seq: seq};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      idx        <= '0;
      crc        <= '0;
      short_mode <= 1'b1;
      seq        <= 8'd1;
      tx.valid   <= 1'b0;
    end else begin
      if (pop) begin
        busy       <= 1'b1;
        idx        <= '0;
        crc        <= '0;
        short_mode <= q_short;
      end
      if (adv) begin
        tx.valid   <= 1'b1;
        tx.tx_byte <= byte_now;
        tx.tx_last <= last_now;
        idx        <= idx + 1'b1;
        if (li < LI_FCS_LO) begin
          crc <= fcs_byte(crc, byte_now);
        end
        if (last_now) begin
          busy <= 1'b0;
          seq  <= seq + 1'b1;
        end
      end else if (tx.valid && tx.ready) begin
        tx.valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/beacon_request_responder.sv
`timescale 1ns / 1ps
// Beacon request responder. Received frame words enter on rx at one per cycle; rx.ready
// drops only while the request queue (QueueDepth entries) is full. The last word of a MAC
// command frame of at least 8 words carrying a beacon request queues one beacon. The
// transmit sequencer then sends the beacon on tx, 28 words (short address) or 34 words
// (long address) ending in the FCS, one word per cycle while tx.ready is high, via an
// output register, pausing between beacons while the sequencer loads the next request.
`include "beacon_request_responder_defines.svh"
module beacon_request_responder #(
  parameter int QueueDepth = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [bcn_pkg::CFG_W-1:0] cfg_data,
  bcn_rx_if.sink                   rx,
  bcn_tx_if.source                 tx
);
  import bcn_pkg::*;

  localparam int CntW = $clog2(QueueDepth + 1);

  cfg_t            cfg;
  rx_status_t      rx_stat;
  tx_status_t      tx_stat;
  logic            q_push;
  logic            q_pop;
  logic            q_short;
  logic            q_full;
  logic            q_empty;
  logic [CntW-1:0] q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pan_id          <= '0;
      cfg.source_address  <= '0;
      cfg.short_mode      <= 1'b1;
      cfg.extended_pan_id <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAN_ID:         cfg.pan_id          <= cfg_data[15:0];
        CFG_SOURCE_ADDRESS: cfg.source_address  <= cfg_data;
        CFG_SHORT_MODE:     cfg.short_mode      <= cfg_data[0];
        CFG_EXT_PAN_ID:     cfg.extended_pan_id <= cfg_data;
        default: ;
      endcase
    end
  end

  bcn_rx u_rx (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .q_full (q_full),
    .push   (q_push),
    .stat   (rx_stat)
  );

  bcn_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (cfg.short_mode),
    .pop       (q_pop),
    .pop_data  (q_short),
    .full      (q_full),
    .empty     (q_empty),
    .count     (q_count)
  );

  bcn_tx u_tx (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_short (q_short),
    .pop     (q_pop),
    .tx      (tx),
    .stat    (tx_stat)
  );

  `BRR_ASSERT_SAME(a_seq_step, clk, rst, tx_stat.seq != $past(tx_stat.seq), tx.valid && tx.tx_last && tx_stat.seq == $past(tx_stat.seq) + 8'd1, "sequence number moved other than at a beacon end")
  `BRR_ASSERT_NEXT(a_frame_restart, clk, rst, rx.valid && rx.ready && rx.rx_last, rx_stat.pos == 4'd0, "receive position not cleared after frame end")
  `BRR_ASSERT_SAME(a_queue_bound, clk, rst, 1'b1, q_count <= CntW'(QueueDepth), "request queue count beyond depth")

endmodule
